// ===== design/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants for the bus mouse card controller
// Request op codes, command codes, status/mode bit masks, window reset
// values and the structs passed between pipeline stages.
// ----------------------------------------------------------------------------
package bmc_pkg;

    // Request op codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_MODE  = 3'd1;
    localparam logic [2:0] OP_CLAMP = 3'd2;
    localparam logic [2:0] OP_CMD   = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;

    // Command byte: bit 7 is don't-care
    localparam logic [7:0] CMD_MASK   = 8'h7F;
    localparam logic [7:0] CMD_SERVE  = 8'h01;
    localparam logic [7:0] CMD_READ   = 8'h02;
    localparam logic [7:0] CMD_CLEAR  = 8'h03;
    localparam logic [7:0] CMD_SETPOS = 8'h04;
    localparam logic [7:0] CMD_HOME   = 8'h05;
    localparam logic [7:0] CMD_INIT   = 8'h06;

    // Clamp axis select
    localparam logic [7:0] AXIS_X = 8'h00;
    localparam logic [7:0] AXIS_Y = 8'h01;

    // Mode / status bit masks
    localparam logic [7:0] M_ON    = 8'h01;
    localparam logic [7:0] M_MOVE  = 8'h02;
    localparam logic [7:0] M_BTN   = 8'h04;
    localparam logic [7:0] M_VBL   = 8'h08;
    localparam logic [7:0] M_MOVED = 8'h20;
    localparam logic [7:0] M_WAS   = 8'h40;
    localparam logic [7:0] M_DOWN  = 8'h80;

    // Clamp window after reset
    localparam logic signed [15:0] WIN_LO_RST = 16'sd0;
    localparam logic signed [15:0] WIN_HI_RST = 16'sd1023;

    typedef struct packed {
        logic signed [15:0] lo_x;
        logic signed [15:0] hi_x;
        logic signed [15:0] lo_y;
        logic signed [15:0] hi_y;
    } window_t;

    // One request as it travels down the pipeline, with the window in
    // effect when it was accepted
    typedef struct packed {
        logic [2:0]         op;
        logic [7:0]         value;
        logic               button;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        window_t            win;
    } item_t;

    // Stage enables for the scaler pipeline
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    typedef struct packed {
        logic [7:0]         status;
        logic [7:0]         mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               irq;
        logic [3:0]         int_pending;
        logic               holes_written;
    } result_t;

endpackage

// ===== design/bmc_req_if.sv =====
// ----------------------------------------------------------------------------
// bmc_req_if: request channel of the bus mouse card controller
// Valid/ready handshake carrying one request per transfer.
// ----------------------------------------------------------------------------
interface bmc_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [7:0]         value;
    logic [9:0]         host_x;
    logic [9:0]         host_y;
    logic               button;
    logic signed [15:0] clamp_min;
    logic signed [15:0] clamp_max;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;

    modport source (
        output valid, op, value, host_x, host_y, button,
               clamp_min, clamp_max, new_x, new_y,
        input  ready
    );

    modport sink (
        input  valid, op, value, host_x, host_y, button,
               clamp_min, clamp_max, new_x, new_y,
        output ready
    );
endinterface

// ===== design/bmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bmc_rsp_if: result channel of the bus mouse card controller
// Valid/ready handshake carrying one result per transfer.
// ----------------------------------------------------------------------------
interface bmc_rsp_if;
    logic               valid;
    logic               ready;
    logic [7:0]         status;
    logic [7:0]         mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               irq;
    logic [3:0]         int_pending;
    logic               holes_written;

    modport source (
        output valid, status, mode, pos_x, pos_y, irq, int_pending, holes_written,
        input  ready
    );

    modport sink (
        input  valid, status, mode, pos_x, pos_y, irq, int_pending, holes_written,
        output ready
    );
endinterface

// ===== design/bmc_scale.sv =====
// ----------------------------------------------------------------------------
// bmc_scale: host pointer to clamp window scaler
// Three-stage pipeline: span times pointer, reciprocal multiply for the
// divide by the screen size, remainder correction, then window clamp.
// ----------------------------------------------------------------------------
module bmc_scale
    import bmc_pkg::*;
#(
    parameter int unsigned SCREEN = 560
)
(
    input  logic               clk,
    input  stage_en_t          en,
    input  logic [9:0]         host,
    input  logic signed [15:0] lo,
    input  logic signed [15:0] hi,
    output logic signed [15:0] scaled
);

    // Product span*h stays below 2^27, so a 27-bit shift keeps the
    // reciprocal quotient within one of the true quotient
    localparam int unsigned    KSH   = 27;
    localparam logic [27:0]    RECIP = 28'((64'd1 << KSH) / SCREEN);
    localparam logic [9:0]     DIV   = 10'(SCREEN);

    logic signed [17:0] span_full;
    logic               inv;
    logic [9:0]         h;
    logic [54:0]        prod_recip;
    logic [26:0]        rem;
    logic [17:0]        q;
    logic signed [17:0] sum;

    logic [26:0]        p2_reg, p3_reg, p4_reg;
    logic [16:0]        span2_reg, span3_reg, span4_reg;
    logic               inv2_reg, inv3_reg, inv4_reg;
    logic signed [15:0] lo2_reg, lo3_reg, lo4_reg;
    logic signed [15:0] hi2_reg, hi3_reg, hi4_reg;
    logic [16:0]        q0_3_reg, q0_4_reg;
    logic [26:0]        qd4_reg;

    assign span_full = 18'(hi) - 18'(lo) + 18'sd1;
    // Empty or inverted window always lands on hi
    assign inv       = (span_full <= 18'sd0);
    assign h         = (host > DIV) ? DIV : host;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            p2_reg    <= 27'(span_full[16:0]) * 27'(h);
            span2_reg <= span_full[16:0];
            inv2_reg  <= inv;
            lo2_reg   <= lo;
            hi2_reg   <= hi;
        end
    end

    assign prod_recip = 55'(p2_reg) * 55'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            q0_3_reg  <= prod_recip[KSH+16:KSH];
            p3_reg    <= p2_reg;
            span3_reg <= span2_reg;
            inv3_reg  <= inv2_reg;
            lo3_reg   <= lo2_reg;
            hi3_reg   <= hi2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            qd4_reg   <= 27'(q0_3_reg) * 27'(DIV);
            q0_4_reg  <= q0_3_reg;
            p4_reg    <= p3_reg;
            span4_reg <= span3_reg;
            inv4_reg  <= inv3_reg;
            lo4_reg   <= lo3_reg;
            hi4_reg   <= hi3_reg;
        end
    end

    // Bump the estimate when the remainder still holds a whole divisor
    assign rem = p4_reg - qd4_reg;
    assign q   = 18'(q0_4_reg) + ((rem >= 27'(DIV)) ? 18'd1 : 18'd0);
    assign sum = 18'(lo4_reg) + $signed({2'b00, q[15:0]});

    // Quotient reaching the span means lo+span = hi+1: clamp to hi
    assign scaled = (inv4_reg || (q >= 18'(span4_reg))) ? hi4_reg : sum[15:0];

endmodule

// ===== design/bmc_core.sv =====
// ----------------------------------------------------------------------------
// bmc_core: card state and result register
// Applies one request to mode, status, pending causes and position and
// holds the resulting state as the result payload.
// ----------------------------------------------------------------------------
module bmc_core
    import bmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd,
    input  item_t              item,
    input  logic signed [15:0] sx,
    input  logic signed [15:0] sy,
    output result_t            res
);

    logic [7:0]         mode_reg, mode_next;
    logic [7:0]         status_reg, status_next;
    logic [3:0]         pend_reg, pend_next;
    logic signed [15:0] cur_x_reg, cur_x_next;
    logic signed [15:0] cur_y_reg, cur_y_next;
    logic               irq_reg, irq_next;
    logic               holes_reg, holes_next;

    logic signed [15:0] cx_cl, cy_cl;
    logic               moved;
    logic [7:0]         pend_tick;
    logic [7:0]         st_read;

    function automatic logic signed [15:0] clamp_win(
        input logic signed [15:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [15:0] r;
        r = (v < lo) ? lo : v;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

    assign cx_cl = clamp_win(cur_x_reg, item.win.lo_x, item.win.hi_x);
    assign cy_cl = clamp_win(cur_y_reg, item.win.lo_y, item.win.hi_y);
    assign moved = (cx_cl != sx) || (cy_cl != sy);

    always_comb
    begin
        mode_next   = mode_reg;
        status_next = status_reg;
        pend_next   = pend_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        irq_next    = 1'b0;
        holes_next  = 1'b0;
        pend_tick   = '0;
        st_read     = status_reg & ~(M_MOVED | M_DOWN | M_WAS);
        if (moved)
        begin
            st_read = st_read | M_MOVED;
        end
        if ((status_reg & M_DOWN) != '0)
        begin
            st_read = st_read | M_WAS;
        end
        if (item.button)
        begin
            st_read = st_read | M_DOWN;
        end
        st_read = st_read & ~(M_MOVE | M_BTN | M_VBL);

        unique case (item.op)
            OP_TICK:
            begin
                // Raise causes only while none are pending
                if (pend_reg == '0)
                begin
                    if ((mode_reg & M_VBL) != '0)
                    begin
                        pend_tick = pend_tick | M_VBL;
                    end
                    if (((mode_reg & M_ON) != '0) && ((mode_reg & M_MOVE) != '0))
                    begin
                        cur_x_next = cx_cl;
                        cur_y_next = cy_cl;
                        if (moved)
                        begin
                            pend_tick = pend_tick | M_MOVE;
                        end
                    end
                    if (((mode_reg & M_ON) != '0) && ((mode_reg & M_BTN) != '0)
                        && item.button)
                    begin
                        pend_tick = pend_tick | M_BTN;
                    end
                    pend_next = pend_tick[3:0];
                    irq_next  = (pend_tick != '0);
                end
            end
            OP_MODE:
            begin
                mode_next = item.value;
                if ((item.value & M_ON) != '0)
                begin
                    status_next = status_reg | M_ON;
                end
                else
                begin
                    status_next = status_reg & ~M_ON;
                end
            end
            OP_CLAMP:
            begin
                // Window lives at the pipeline entry
            end
            OP_CMD:
            begin
                holes_next = 1'b1;
                unique case (item.value & CMD_MASK)
                    CMD_SERVE:
                    begin
                        status_next = status_reg | {4'b0000, pend_reg};
                        pend_next   = '0;
                    end
                    CMD_READ:
                    begin
                        status_next = st_read;
                        cur_x_next  = sx;
                        cur_y_next  = sy;
                    end
                    CMD_CLEAR:
                    begin
                        status_next = status_reg & ~(M_MOVE | M_BTN | M_VBL
                                                     | M_MOVED | M_DOWN | M_WAS);
                    end
                    CMD_SETPOS:
                    begin
                        cur_x_next = clamp_win(item.new_x, item.win.lo_x, item.win.hi_x);
                        cur_y_next = clamp_win(item.new_y, item.win.lo_y, item.win.hi_y);
                    end
                    CMD_HOME:
                    begin
                        cur_x_next = item.win.lo_x;
                        cur_y_next = item.win.lo_y;
                    end
                    CMD_INIT:
                    begin
                        mode_next   = '0;
                        status_next = '0;
                        pend_next   = '0;
                        cur_x_next  = '0;
                        cur_y_next  = '0;
                    end
                    default:
                    begin
                        holes_next = 1'b0;
                    end
                endcase
            end
            OP_RESET:
            begin
                mode_next   = '0;
                status_next = '0;
                pend_next   = '0;
                cur_x_next  = '0;
                cur_y_next  = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            status_reg <= '0;
            pend_reg   <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            irq_reg    <= 1'b0;
            holes_reg  <= 1'b0;
        end
        else if (upd)
        begin
            mode_reg   <= mode_next;
            status_reg <= status_next;
            pend_reg   <= pend_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            irq_reg    <= irq_next;
            holes_reg  <= holes_next;
        end
    end

    assign res.status        = status_reg;
    assign res.mode          = mode_reg;
    assign res.pos_x         = cur_x_reg;
    assign res.pos_y         = cur_y_reg;
    assign res.irq           = irq_reg;
    assign res.int_pending   = pend_reg;
    assign res.holes_written = holes_reg;

endmodule

// ===== design/bus_mouse_card_controller.sv =====
// ----------------------------------------------------------------------------
// bus_mouse_card_controller: mouse interface card controller
// Takes tick, mode, clamp, command and reset requests, scales the host
// pointer into per-axis clamp windows and reports the card state.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------
//   req     | in  | valid / ready | op value host_x host_y button clamp_min
//           |     |               | clamp_max new_x new_y
//   rsp     | out | valid / ready | status mode pos_x pos_y irq int_pending
//           |     |               | holes_written
//
// One result per request. Five stages: input register, three scaler stages
// (span multiply, reciprocal multiply, remainder correction) and the result
// register; it takes one request per cycle unless the result channel stalls.
// Reset (rst_n low) clears all stage valids, the card state and the clamp
// window to 0..1023 at once; no clearing pass.
// Each stage holds only while its successor is full and stalled, so a
// waiting result still lets the earlier stages fill.
//
module bus_mouse_card_controller
    import bmc_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = 560,
    parameter int unsigned SCREEN_HEIGHT = 384
)
(
    input  logic      clk,
    input  logic      rst_n,
    bmc_req_if.sink   req,
    bmc_rsp_if.source rsp
);

    // Stage valids and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic accept;
    stage_en_t scale_en;

    // Clamp window at the entry; window writes take effect in request order
    window_t win_reg, win_next;

    item_t      item1_reg, item2_reg, item3_reg, item4_reg;
    logic [9:0] hx1_reg, hy1_reg;

    logic signed [15:0] sx, sy;
    result_t            res;

    assign en5    = !v5_reg || rsp.ready;
    assign en4    = !v4_reg || en5;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = req.valid && en1;

    assign req.ready = en1;

    assign scale_en.s2 = en2;
    assign scale_en.s3 = en3;
    assign scale_en.s4 = en4;

    // Window update for the accepted request: clamp write per axis, reset
    // and init command restore defaults
    always_comb
    begin
        win_next = win_reg;
        unique case (req.op)
            OP_CLAMP:
            begin
                if (req.value == AXIS_X)
                begin
                    win_next.lo_x = req.clamp_min;
                    win_next.hi_x = req.clamp_max;
                end
                else if (req.value == AXIS_Y)
                begin
                    win_next.lo_y = req.clamp_min;
                    win_next.hi_y = req.clamp_max;
                end
            end
            OP_CMD:
            begin
                if ((req.value & CMD_MASK) == CMD_INIT)
                begin
                    win_next.lo_x = WIN_LO_RST;
                    win_next.hi_x = WIN_HI_RST;
                    win_next.lo_y = WIN_LO_RST;
                    win_next.hi_y = WIN_HI_RST;
                end
            end
            OP_RESET:
            begin
                win_next.lo_x = WIN_LO_RST;
                win_next.hi_x = WIN_HI_RST;
                win_next.lo_y = WIN_LO_RST;
                win_next.hi_y = WIN_HI_RST;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.lo_x <= WIN_LO_RST;
            win_reg.hi_x <= WIN_HI_RST;
            win_reg.lo_y <= WIN_LO_RST;
            win_reg.hi_y <= WIN_HI_RST;
        end
        else if (accept)
        begin
            win_reg <= win_next;
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= req.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Request payload down the pipe; each request carries the window in
    // effect before its own update
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            item1_reg.op     <= req.op;
            item1_reg.value  <= req.value;
            item1_reg.button <= req.button;
            item1_reg.new_x  <= req.new_x;
            item1_reg.new_y  <= req.new_y;
            item1_reg.win    <= win_reg;
            hx1_reg          <= req.host_x;
            hy1_reg          <= req.host_y;
        end
        if (en2)
        begin
            item2_reg <= item1_reg;
        end
        if (en3)
        begin
            item3_reg <= item2_reg;
        end
        if (en4)
        begin
            item4_reg <= item3_reg;
        end
    end

    bmc_scale #(
        .SCREEN (SCREEN_WIDTH)
    ) u_scale_x (
        .clk    (clk),
        .en     (scale_en),
        .host   (hx1_reg),
        .lo     (item1_reg.win.lo_x),
        .hi     (item1_reg.win.hi_x),
        .scaled (sx)
    );

    bmc_scale #(
        .SCREEN (SCREEN_HEIGHT)
    ) u_scale_y (
        .clk    (clk),
        .en     (scale_en),
        .host   (hy1_reg),
        .lo     (item1_reg.win.lo_y),
        .hi     (item1_reg.win.hi_y),
        .scaled (sy)
    );

    // State update and result register fire as a request leaves stage 4
    bmc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (v4_reg && en5),
        .item  (item4_reg),
        .sx    (sx),
        .sy    (sy),
        .res   (res)
    );

    assign rsp.valid         = v5_reg;
    assign rsp.status        = res.status;
    assign rsp.mode          = res.mode;
    assign rsp.pos_x         = res.pos_x;
    assign rsp.pos_y         = res.pos_y;
    assign rsp.irq           = res.irq;
    assign rsp.int_pending   = res.int_pending;
    assign rsp.holes_written = res.holes_written;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: request/result bench for the bus mouse card controller
// Drives tick, mode, clamp, command and reset requests through the request
// channel with random gaps. A cycle-free model of the card predicts one
// result per accepted request. Each result taken from the result channel,
// which stalls at random, is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import bmc_pkg::*;
();

    localparam int SCREEN_W        = 560;
    localparam int SCREEN_H        = 384;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int MAX_REPORTS     = 10;

    // Known results: card state right after reset, after the init command,
    // and after switching the card on with every interrupt source enabled.
    localparam result_t RSP_CLEAR = '{status: 8'h00, mode: 8'h00, pos_x: 16'sd0,
                                      pos_y: 16'sd0, irq: 1'b0, int_pending: 4'h0,
                                      holes_written: 1'b0};
    localparam result_t RSP_INIT  = '{status: 8'h00, mode: 8'h00, pos_x: 16'sd0,
                                      pos_y: 16'sd0, irq: 1'b0, int_pending: 4'h0,
                                      holes_written: 1'b1};
    localparam result_t RSP_ALL_ON = '{status: M_ON, mode: M_ON | M_MOVE | M_BTN | M_VBL,
                                       pos_x: 16'sd0, pos_y: 16'sd0, irq: 1'b0,
                                       int_pending: 4'h0, holes_written: 1'b0};

    typedef struct packed {
        bit [2:0]         op;
        bit [7:0]         value;
        bit [9:0]         host_x;
        bit [9:0]         host_y;
        bit               button;
        bit signed [15:0] clamp_min;
        bit signed [15:0] clamp_max;
        bit signed [15:0] new_x;
        bit signed [15:0] new_y;
    } card_req_t;

    // One row of the directed table: the request, and a typed-in result
    // where one can be read off directly (pinned) instead of predicted.
    typedef struct {
        card_req_t rq;
        bit        pinned;
        result_t   want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    bmc_req_if req_bus ();
    bmc_rsp_if rsp_bus ();

    bus_mouse_card_controller #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // ------------------------------------------------------------------------
    // Card model state
    // ------------------------------------------------------------------------
    bit [7:0] card_mode;
    bit [7:0] card_status;
    bit [3:0] card_pend;
    int       card_x;
    int       card_y;
    int       win_lo_x;
    int       win_hi_x;
    int       win_lo_y;
    int       win_hi_y;

    result_t  expected_results[$];
    int       mismatch_count;
    int       send_quiet;
    int       take_quiet;

    // Side band that travels with each request: a typed-in result, if any
    bit       pin_valid;
    result_t  pin_value;

    // ------------------------------------------------------------------------
    // Card model
    // ------------------------------------------------------------------------
    function automatic void card_clear();
        card_mode   = 8'h00;
        card_status = 8'h00;
        card_pend   = 4'h0;
        card_x      = 0;
        card_y      = 0;
        win_lo_x    = WIN_LO_RST;
        win_hi_x    = WIN_HI_RST;
        win_lo_y    = WIN_LO_RST;
        win_hi_y    = WIN_HI_RST;
    endfunction

    // Raise to lo first, then lower to hi: an inverted window ends at hi
    function automatic int win_clamp(int v, int lo, int hi);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    function automatic int scale_axis(int host, int screen, int lo, int hi);
        int h;
        int s;
        h = (host > screen) ? screen : host;
        // Signed int division truncates toward zero, as the card does
        s = ((hi - lo + 1) * h) / screen + lo;
        return win_clamp(s, lo, hi);
    endfunction

    // Scale the host pointer into the window and pull the current position
    // back inside it.
    function automatic void track_pointer(card_req_t rq, output int sx, output int sy);
        sx     = scale_axis(int'(rq.host_x), SCREEN_W, win_lo_x, win_hi_x);
        sy     = scale_axis(int'(rq.host_y), SCREEN_H, win_lo_y, win_hi_y);
        card_x = win_clamp(card_x, win_lo_x, win_hi_x);
        card_y = win_clamp(card_y, win_lo_y, win_hi_y);
    endfunction

    function automatic result_t card_step(card_req_t rq);
        result_t  r;
        bit [7:0] prev;
        int       sx;
        int       sy;
        r.irq           = 1'b0;
        r.holes_written = 1'b0;
        case (rq.op)
            OP_TICK:
                // Raise causes only while none is pending
                if (card_pend == 4'h0)
                begin
                    if (card_mode & M_VBL)
                        card_pend |= 4'(M_VBL);
                    if (card_mode & M_ON)
                    begin
                        if (card_mode & M_MOVE)
                        begin
                            track_pointer(rq, sx, sy);
                            if (card_x != sx || card_y != sy)
                                card_pend |= 4'(M_MOVE);
                        end
                        if ((card_mode & M_BTN) && rq.button)
                            card_pend |= 4'(M_BTN);
                    end
                    r.irq = (card_pend != 4'h0);
                end
            OP_MODE:
            begin
                card_mode = rq.value;
                if (rq.value & M_ON)
                    card_status |= M_ON;
                else
                    card_status &= ~M_ON;
            end
            OP_CLAMP:
                if (rq.value == AXIS_X)
                begin
                    win_lo_x = rq.clamp_min;
                    win_hi_x = rq.clamp_max;
                end
                else if (rq.value == AXIS_Y)
                begin
                    win_lo_y = rq.clamp_min;
                    win_hi_y = rq.clamp_max;
                end
            OP_CMD:
            begin
                r.holes_written = 1'b1;
                case (rq.value & CMD_MASK)
                    CMD_SERVE:
                    begin
                        card_status |= {4'h0, card_pend};
                        card_pend    = 4'h0;
                    end
                    CMD_READ:
                    begin
                        track_pointer(rq, sx, sy);
                        prev         = card_status;
                        card_status &= ~(M_MOVED | M_DOWN | M_WAS);
                        if (card_x != sx || card_y != sy)
                            card_status |= M_MOVED;
                        card_x = sx;
                        card_y = sy;
                        if (prev & M_DOWN)
                            card_status |= M_WAS;
                        if (rq.button)
                            card_status |= M_DOWN;
                        card_status &= ~(M_MOVE | M_BTN | M_VBL);
                    end
                    CMD_CLEAR:
                        card_status &= ~(M_MOVE | M_BTN | M_VBL | M_MOVED | M_DOWN | M_WAS);
                    CMD_SETPOS:
                    begin
                        card_x = rq.new_x;
                        card_y = rq.new_y;
                        track_pointer(rq, sx, sy);
                    end
                    CMD_HOME:
                    begin
                        card_x = win_lo_x;
                        card_y = win_lo_y;
                    end
                    CMD_INIT:
                        card_clear();
                    default:
                        r.holes_written = 1'b0;
                endcase
            end
            OP_RESET:
                card_clear();
            default:
                ;   // unused op codes leave the card alone
        endcase
        r.status      = card_status;
        r.mode        = card_mode;
        r.pos_x       = 16'(card_x);
        r.pos_y       = 16'(card_y);
        r.int_pending = card_pend;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic card_req_t mk(bit [2:0] op, bit [7:0] value, bit [9:0] hx,
                                     bit [9:0] hy, bit btn, int cmin, int cmax,
                                     int nx, int ny);
        card_req_t rq;
        rq.op        = op;
        rq.value     = value;
        rq.host_x    = hx;
        rq.host_y    = hy;
        rq.button    = btn;
        rq.clamp_min = 16'(cmin);
        rq.clamp_max = 16'(cmax);
        rq.new_x     = 16'(nx);
        rq.new_y     = 16'(ny);
        return rq;
    endfunction

    // Draw a random wait; now and then start a run of back-to-back
    // items with no wait at all.
    function automatic int pick_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            quiet = $urandom_range(20, 60);
        return $urandom_range(0, 10);
    endfunction

    // Random request shaped toward a working card: mostly ticks, serve and
    // read commands, mode writes that switch the card on, and small clamp
    // windows, with a share of raw noise in every field.
    function automatic card_req_t random_request();
        card_req_t rq;
        int        pick;
        int        lo;
        bit [7:0]  code;
        rq   = card_req_t'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 30)
            rq.op = OP_TICK;
        else if (pick < 62)
            rq.op = OP_CMD;
        else if (pick < 74)
            rq.op = OP_MODE;
        else if (pick < 92)
            rq.op = OP_CLAMP;
        else if (pick < 95)
            rq.op = OP_RESET;
        else
            rq.op = 3'($urandom_range(5, 7));

        case (rq.op)
            OP_MODE:
                if ($urandom_range(0, 3) != 0)
                    rq.value = 8'($urandom_range(0, 15)) | M_ON;
            OP_CMD:
                if ($urandom_range(0, 6) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: code = CMD_SERVE;
                        3, 4, 5: code = CMD_READ;
                        6:       code = CMD_CLEAR;
                        7:       code = CMD_SETPOS;
                        8:       code = CMD_HOME;
                        default: code = ($urandom_range(0, 2) == 0) ? CMD_INIT : CMD_READ;
                    endcase
                    rq.value = code | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
                end
            OP_CLAMP:
                if ($urandom_range(0, 9) != 0)
                    rq.value = $urandom_range(0, 1) ? AXIS_Y : AXIS_X;
            default:
                ;
        endcase

        // Pointer mostly on screen, sometimes past it to hit saturation
        if ($urandom_range(0, 9) < 7)
            rq.host_x = 10'($urandom_range(0, SCREEN_W));
        if ($urandom_range(0, 9) < 7)
            rq.host_y = 10'($urandom_range(0, SCREEN_H));

        // Windows mostly small and sane, some inverted, some raw
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            lo = int'($urandom_range(0, 1200)) - 600;
            rq.clamp_min = 16'(lo);
            rq.clamp_max = 16'(lo + int'($urandom_range(0, 700)));
        end
        else if (pick < 8)
        begin
            lo = int'($urandom_range(0, 1200)) - 600;
            rq.clamp_min = 16'(lo);
            rq.clamp_max = 16'(lo - int'($urandom_range(1, 300)));
        end

        if ($urandom_range(0, 1) != 0)
        begin
            rq.new_x = 16'(int'($urandom_range(0, 2400)) - 1200);
            rq.new_y = 16'(int'($urandom_range(0, 2400)) - 1200);
        end
        return rq;
    endfunction

    // Put one request on the channel and hold it until it is taken. Valid
    // stays high into the next request when no gap is drawn.
    task automatic send_request(input card_req_t rq, input bit pin, input result_t want);
        int gap;
        gap = pick_wait(send_quiet);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.op        <= rq.op;
        req_bus.value     <= rq.value;
        req_bus.host_x    <= rq.host_x;
        req_bus.host_y    <= rq.host_y;
        req_bus.button    <= rq.button;
        req_bus.clamp_min <= rq.clamp_min;
        req_bus.clamp_max <= rq.clamp_max;
        req_bus.new_x     <= rq.new_x;
        req_bus.new_y     <= rq.new_y;
        pin_valid         <= pin;
        pin_value         <= want;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor: check each taken result against the oldest expectation, then
    // advance the model on each accepted request.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t   got;
        result_t   want;
        card_req_t seen;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got.status        = rsp_bus.status;
            got.mode          = rsp_bus.mode;
            got.pos_x         = rsp_bus.pos_x;
            got.pos_y         = rsp_bus.pos_y;
            got.irq           = rsp_bus.irq;
            got.int_pending   = rsp_bus.int_pending;
            got.holes_written = rsp_bus.holes_written;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: status %h mode %h",
                             $realtime, got.status, got.mode);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.mode !== want.mode ||
                    got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                    got.irq !== want.irq || got.int_pending !== want.int_pending ||
                    got.holes_written !== want.holes_written)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch, expected status %h mode %h pos %0d,%0d",
                                 $realtime, want.status, want.mode, want.pos_x, want.pos_y);
                        $display("    irq %b pend %h holes %b; got status %h mode %h",
                                 want.irq, want.int_pending, want.holes_written,
                                 got.status, got.mode);
                        $display("    pos %0d,%0d irq %b pend %h holes %b",
                                 got.pos_x, got.pos_y, got.irq, got.int_pending,
                                 got.holes_written);
                    end
                end
            end
        end

        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            seen.op        = req_bus.op;
            seen.value     = req_bus.value;
            seen.host_x    = req_bus.host_x;
            seen.host_y    = req_bus.host_y;
            seen.button    = req_bus.button;
            seen.clamp_min = req_bus.clamp_min;
            seen.clamp_max = req_bus.clamp_max;
            seen.new_x     = req_bus.new_x;
            seen.new_y     = req_bus.new_y;
            // Always advance the model; a pinned row only replaces what is
            // compared against.
            want = card_step(seen);
            expected_results.push_back(pin_valid ? pin_value : want);
        end
    end

    // ------------------------------------------------------------------------
    // Result side: stall ready at random, one draw per result taken
    // ------------------------------------------------------------------------
    initial
    begin : result_taker
        int stall;
        rsp_bus.ready <= 1'b0;
        take_quiet = 0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_wait(take_quiet);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_bus.valid && rsp_bus.ready));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    directed_row_t directed_rows[$];

    initial
    begin : stimulus
        localparam bit [7:0] MODE_ALL = M_ON | M_MOVE | M_BTN | M_VBL;
        directed_row_t row;
        card_req_t     rq;

        // Hold every input at a known value through reset
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.op        <= OP_TICK;
        req_bus.value     <= 8'h00;
        req_bus.host_x    <= 10'd0;
        req_bus.host_y    <= 10'd0;
        req_bus.button    <= 1'b0;
        req_bus.clamp_min <= 16'sd0;
        req_bus.clamp_max <= 16'sd0;
        req_bus.new_x     <= 16'sd0;
        req_bus.new_y     <= 16'sd0;
        pin_valid         <= 1'b0;
        pin_value         <= RSP_CLEAR;
        mismatch_count = 0;
        send_quiet     = 0;
        card_clear();

        // Reset request, then a tick with the card off: nothing may move
        directed_rows.push_back('{mk(OP_RESET, 8'h00, 0, 0, 0, 0, 0, 0, 0), 1, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_TICK, 8'h00, 1023, 1023, 1, 0, 0, 0, 0), 1, RSP_CLEAR});
        // Switch on with every interrupt source
        directed_rows.push_back('{mk(OP_MODE, MODE_ALL, 0, 0, 0, 0, 0, 0, 0), 1, RSP_ALL_ON});
        // Tick raising move, button and VBL at once; then a tick while pending
        directed_rows.push_back('{mk(OP_TICK, 8'h00, 1023, 1023, 1, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, CMD_SERVE, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        // Read at the screen corner with the button down, then back at origin
        directed_rows.push_back('{mk(OP_CMD, CMD_READ, 10'(SCREEN_W), 10'(SCREEN_H), 1,
                                     0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, CMD_READ, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        // Widest window on x, inverted window on y, unknown axis ignored
        directed_rows.push_back('{mk(OP_CLAMP, AXIS_X, 0, 0, 0, -32768, 32767, 0, 0),
                                  0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CLAMP, AXIS_Y, 0, 0, 0, 32767, -32768, 0, 0),
                                  0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CLAMP, 8'hFF, 0, 0, 0, 5, 6, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, CMD_READ, 1023, 1023, 1, 0, 0, 0, 0), 0, RSP_CLEAR});
        // Set position at the signed extremes, home, set position with bit 7
        directed_rows.push_back('{mk(OP_CMD, CMD_SETPOS, 0, 0, 0, 0, 0, 32767, -32768),
                                  0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, CMD_HOME, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, CMD_SETPOS | 8'h80, 0, 0, 0, 0, 0, -32768, 32767),
                                  0, RSP_CLEAR});
        // Unknown command bytes write nothing
        directed_rows.push_back('{mk(OP_CMD, 8'h00, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, 8'hFF, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        // Unused op codes with every other field at all ones
        directed_rows.push_back('{mk(3'd5, 8'hFF, 1023, 1023, 1, -1, -1, -1, -1), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(3'd7, 8'hFF, 1023, 1023, 1, -1, -1, -1, -1), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_CMD, CMD_INIT, 0, 0, 0, 0, 0, 0, 0), 1, RSP_INIT});
        // Card off but VBL enabled: a tick raises VBL only
        directed_rows.push_back('{mk(OP_MODE, 8'hFE, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_TICK, 8'h00, 100, 100, 1, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_MODE, M_ON | M_BTN, 0, 0, 0, 0, 0, 0, 0), 0, RSP_CLEAR});
        directed_rows.push_back('{mk(OP_TICK, 8'h00, 100, 100, 1, 0, 0, 0, 0), 0, RSP_CLEAR});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.rq, row.pinned, row.want);
        end
        drain_results();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            rq = random_request();
            send_request(rq, 1'b0, RSP_CLEAR);
            // Let the pipe run dry midway and now and then
            if (n == RANDOM_REQUESTS / 2 || $urandom_range(0, 199) == 0)
                drain_results();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog: far beyond the slowest legal run
    // ------------------------------------------------------------------------
    initial
    begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
